// ----- hdl/polyphase_interpolator_unit_assert.svh -----
// -----------------------------------------------------------------------------
// Polyphase interpolator assertion macros
// Concurrent checks that disappear when the design is synthesised.
// -----------------------------------------------------------------------------
`ifndef POLYPHASE_INTERPOLATOR_UNIT_ASSERT_SVH
`define POLYPHASE_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must never hold.
`define PPI_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

// The consequent must hold in the same cycle as the antecedent.
`define PPI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define PPI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define PPI_ASSERT_NEVER(name, clk, rst_n, cond)
`define PPI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PPI_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/ppi_pkg.sv -----
// -----------------------------------------------------------------------------
// Polyphase interpolator package
// Sizes, shared types and the filter kernel table built at elaboration.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int FACTOR         = 4;
    localparam int TAPS_PER_INPUT = 64;
    localparam int CHANNELS       = 8;

    localparam int CHAN_IN_W   = 3;
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_OUT_W = 2;
    localparam int COEF_W      = 18;
    localparam int ROUND_SHIFT = 16;

    localparam int HIST_LEN   = TAPS_PER_INPUT + 1;
    localparam int ROM_LEN    = TAPS_PER_INPUT * FACTOR + 1;
    localparam int HIST_IDX_W = $clog2(HIST_LEN);
    localparam int TAP_IDX_W  = $clog2(ROM_LEN);
    localparam int PHASE_W    = (FACTOR > 1) ? $clog2(FACTOR) : 1;
    localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH  = CHANNELS * HIST_LEN;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + $clog2(HIST_LEN) + 1;

    localparam int FIFO_DEPTH = FACTOR;
    localparam int FIFO_PTR_W = (FACTOR > 1) ? $clog2(FACTOR) : 1;
    localparam int FIFO_CNT_W = $clog2(FACTOR + 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (ROUND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

    // Fixed-point constants of the kernel construction (Q30 unless noted).
    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint unsigned Q30_ONE_U   = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned PI_Q28      = 64'd843314857;
    localparam longint          BLK_A0      = 64'sd450971566;
    localparam longint          BLK_A2      = 64'sd85899346;
    localparam longint          ROM_SPAN    = longint'(ROM_LEN - 1);
    localparam longint unsigned ROM_SPAN_U  = longint'(ROM_LEN - 1);
    localparam longint          TURN        = longint'(4 * FACTOR);
    localparam longint unsigned TURN_U      = longint'(4 * FACTOR);
    localparam longint unsigned FACTOR_U    = longint'(FACTOR);
    localparam longint          COEF_MAX    = (64'sd1 <<< (COEF_W - 1)) - 1;
    localparam longint          COEF_MIN    = -(64'sd1 <<< (COEF_W - 1));

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [PHASE_W-1:0]   phase;
    } ppi_tag_t;

    typedef struct packed {
        ppi_tag_t             tag;
        logic [TAP_IDX_W-1:0] tap;
    } ppi_issue_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0]   data;
    } ppi_wr_t;

    typedef struct packed {
        logic                       push;
        logic signed [SAMPLE_W-1:0] value;
        logic [PHASE_W-1:0]         phase;
    } ppi_result_t;

    // Restoring division, used only while the kernel table is elaborated.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // Sine of an angle given in turns scaled by 2^32, Taylor series to x^13.
    function automatic longint sine_q30(logic [31:0] ang);
        logic [1:0]      quad;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        quad = ang[31:30];
        f = longint'(ang[29:0]);
        if (quad[0])
        begin
            f = Q30_ONE_U - f;
        end
        x   = (f * HALF_PI_Q30) >> 30;
        x2  = (x * x) >> 30;
        acc = longint'(x);
        t   = ((x * x2) >> 30) / 64'd6;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 64'd156;
        acc = acc + longint'(t);
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > Q30_ONE)
        begin
            acc = Q30_ONE;
        end
        return quad[1] ? -acc : acc;
    endfunction

    function automatic longint cosine_q30(logic [31:0] ang);
        logic [31:0] shifted;
        shifted = ang + 32'h4000_0000;
        return sine_q30(shifted);
    endfunction

    // Windowed sinc value of one kernel tap before normalisation.
    function automatic longint raw_tap(int idx);
        longint          d;
        longint          dm;
        longint          s;
        longint          sc;
        longint          w;
        longint unsigned smag;
        longint unsigned dmag;
        longint unsigned q;
        logic [63:0]     wide;
        logic [31:0]     a;
        logic [31:0]     a1;
        logic [31:0]     a2;
        d = 2 * longint'(idx) - ROM_SPAN;
        if (d == 0)
        begin
            sc = Q30_ONE;
        end
        else
        begin
            dm   = ((d % TURN) + TURN) % TURN;
            wide = (longint'(dm) << 32) / TURN_U;
            a    = wide[31:0];
            s    = sine_q30(a);
            smag = (s < 0) ? -s : s;
            dmag = (d < 0) ? -d : d;
            q    = div_u64((smag * (2 * FACTOR_U)) << 28, PI_Q28 * dmag);
            sc   = ((s < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        end
        wide = (longint'(idx) << 32) / ROM_SPAN_U;
        a1   = wide[31:0];
        wide = (longint'(2 * idx) << 32) / ROM_SPAN_U;
        a2   = wide[31:0];
        w = BLK_A0 - cosine_q30(a1) / 64'sd2 + (cosine_q30(a2) * BLK_A2) / Q30_ONE;
        return (sc * w) / Q30_ONE;
    endfunction

    // Whole kernel, normalised to unity DC gain and scaled by the factor.
    function automatic logic [ROM_LEN*COEF_W-1:0] build_rom();
        logic [ROM_LEN*COEF_W-1:0] rom;
        longint                    total;
        longint                    raw;
        longint                    num;
        longint                    c;
        longint unsigned           mag;
        longint unsigned           q;
        rom   = '0;
        total = 0;
        for (int i = 0; i < ROM_LEN; i++)
        begin
            total = total + raw_tap(i);
        end
        for (int i = 0; i < ROM_LEN; i++)
        begin
            raw = raw_tap(i);
            c   = 0;
            if (total > 0)
            begin
                num = raw * longint'(FACTOR) * 64'sd65536;
                mag = (num < 0) ? -num : num;
                q   = div_u64(mag + longint'(total >> 1), longint'(total));
                c   = (num < 0) ? -longint'(q) : longint'(q);
            end
            if (c > COEF_MAX)
            begin
                c = COEF_MAX;
            end
            if (c < COEF_MIN)
            begin
                c = COEF_MIN;
            end
            rom[i*COEF_W +: COEF_W] = c[COEF_W-1:0];
        end
        return rom;
    endfunction

    localparam logic [ROM_LEN*COEF_W-1:0] TAP_ROM = build_rom();

    function automatic logic signed [COEF_W-1:0] tap_coef(logic [TAP_IDX_W-1:0] idx);
        return TAP_ROM[int'(idx)*COEF_W +: COEF_W];
    endfunction

    // Channel numbers past the configured count wrap round.
    function automatic logic [CHAN_W-1:0] chan_reduce(logic [CHAN_IN_W-1:0] ch);
        logic [CHAN_IN_W-1:0]        v;
        logic [CHAN_IN_W+CHAN_W-1:0] ext;
        v = ch;
        for (int n = 0; n < (1 << CHAN_IN_W); n++)
        begin
            if (int'(v) >= CHANNELS)
            begin
                v = v - CHAN_IN_W'(CHANNELS);
            end
        end
        ext = {CHAN_W'(0), v};
        return ext[CHAN_W-1:0];
    endfunction

    function automatic logic [PHASE_OUT_W-1:0] phase_out(logic [PHASE_W-1:0] ph);
        logic [PHASE_W+PHASE_OUT_W-1:0] ext;
        ext = {{PHASE_OUT_W{1'b0}}, ph};
        return ext[PHASE_OUT_W-1:0];
    endfunction

endpackage

// ----- hdl/ppi_ram.sv -----
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 520
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/ppi_seq.sv -----
// -----------------------------------------------------------------------------
// Polyphase interpolator sequencer
// Clears the history after reset, stores each sample and walks the taps.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppi_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [ppi_pkg::CHAN_IN_W-1:0]         channel,
    input  logic signed [ppi_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  result_pop,
    output ppi_pkg::ppi_wr_t                      ram_wr,
    output logic [ppi_pkg::MEM_ADDR_W-1:0]        ram_rd_addr,
    output ppi_pkg::ppi_issue_t                   issue,
    output logic [ppi_pkg::FIFO_CNT_W-1:0]        credit_used
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam int AW = ppi_pkg::MEM_ADDR_W;
    localparam int HW = ppi_pkg::HIST_IDX_W;
    localparam int TW = ppi_pkg::TAP_IDX_W;
    localparam int PW = ppi_pkg::PHASE_W;
    localparam int CW = ppi_pkg::FIFO_CNT_W;

    state_t                     state_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [HW-1:0]              wp_reg [ppi_pkg::CHANNELS];
    logic [AW-1:0]              base_reg;
    logic [HW-1:0]              start_rd_reg;
    logic [HW-1:0]              rd_reg;
    logic [TW-1:0]              tap_reg;
    logic [PW-1:0]              phase_reg;
    logic                       first_reg;
    logic [CW-1:0]              credit_reg;
    logic [CW-1:0]              credit_next;

    logic [ppi_pkg::CHAN_W-1:0] ch;
    logic [HW-1:0]              wp_cur;
    logic [AW-1:0]              chan_base;
    logic                       accept;
    logic                       last_tap;
    logic                       can_issue;
    logic                       issuing;
    logic [PW-1:0]              phase_inc;

    assign ch         = ppi_pkg::chan_reduce(channel);
    assign wp_cur     = wp_reg[ch];
    assign chan_base  = AW'(ch) * AW'(ppi_pkg::HIST_LEN);
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign last_tap   = (({1'b0, tap_reg} + (TW + 1)'(ppi_pkg::FACTOR))
                         >= (TW + 1)'(ppi_pkg::ROM_LEN));
    // A phase only starts once the result queue has room reserved for it.
    assign can_issue  = !first_reg || (credit_reg < CW'(ppi_pkg::FIFO_DEPTH));
    assign issuing    = (state_reg == ST_RUN) && can_issue;
    assign phase_inc  = phase_reg + 1'b1;

    always_comb
    begin
        credit_next = credit_reg;
        if (issuing && first_reg && !result_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(issuing && first_reg) && result_pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_addr_reg;
            ram_wr.data = '0;
        end
        else
        begin
            ram_wr.en   = accept;
            ram_wr.addr = chan_base + AW'(wp_cur);
            ram_wr.data = sample;
        end
    end

    assign ram_rd_addr     = base_reg + AW'(rd_reg);
    assign issue.tag.valid = issuing;
    assign issue.tag.first = first_reg;
    assign issue.tag.last  = last_tap;
    assign issue.tag.phase = phase_reg;
    assign issue.tap       = tap_reg;
    assign credit_used     = credit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            for (int i = 0; i < ppi_pkg::CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
            base_reg     <= '0;
            start_rd_reg <= '0;
            rd_reg       <= '0;
            tap_reg      <= '0;
            phase_reg    <= '0;
            first_reg    <= 1'b0;
            credit_reg   <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(ppi_pkg::MEM_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wp_reg[ch]   <= (wp_cur == HW'(ppi_pkg::HIST_LEN - 1)) ?
                                        '0 : wp_cur + 1'b1;
                        base_reg     <= chan_base;
                        // The newest sample is the one just written.
                        start_rd_reg <= wp_cur;
                        rd_reg       <= wp_cur;
                        tap_reg      <= '0;
                        phase_reg    <= '0;
                        first_reg    <= 1'b1;
                        state_reg    <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (issuing)
                    begin
                        if (last_tap)
                        begin
                            if (phase_reg == PW'(ppi_pkg::FACTOR - 1))
                            begin
                                state_reg <= ST_IDLE;
                            end
                            phase_reg <= phase_inc;
                            tap_reg   <= TW'(phase_inc);
                            rd_reg    <= start_rd_reg;
                            first_reg <= 1'b1;
                        end
                        else
                        begin
                            tap_reg   <= tap_reg + TW'(ppi_pkg::FACTOR);
                            rd_reg    <= (rd_reg == '0) ?
                                         HW'(ppi_pkg::HIST_LEN - 1) : rd_reg - 1'b1;
                            first_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/ppi_mac.sv -----
// -----------------------------------------------------------------------------
// Polyphase interpolator multiply-accumulate
// Kernel lookup, one product per cycle, accumulation, rounding and saturation.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppi_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppi_pkg::ppi_issue_t                 issue,
    input  logic [ppi_pkg::SAMPLE_W-1:0]        ram_rdata,
    output ppi_pkg::ppi_result_t                result
);

    localparam int AW = ppi_pkg::ACC_W;

    ppi_pkg::ppi_tag_t                      s1_tag_reg;
    ppi_pkg::ppi_tag_t                      s2_tag_reg;
    logic signed [ppi_pkg::COEF_W-1:0]      coef_reg;
    logic signed [ppi_pkg::PROD_W-1:0]      prod_reg;
    logic signed [AW-1:0]                   acc_reg;
    logic signed [AW-1:0]                   acc_next;
    logic                                   done_reg;
    logic [ppi_pkg::PHASE_W-1:0]            done_phase_reg;

    logic signed [AW-1:0]                   rounded;
    logic signed [AW-1:0]                   shifted;

    assign acc_next = s2_tag_reg.first ? AW'(prod_reg) : acc_reg + AW'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg     <= '0;
            s2_tag_reg     <= '0;
            done_reg       <= 1'b0;
            done_phase_reg <= '0;
        end
        else
        begin
            s1_tag_reg     <= issue.tag;
            s2_tag_reg     <= s1_tag_reg;
            done_reg       <= s2_tag_reg.valid && s2_tag_reg.last;
            done_phase_reg <= s2_tag_reg.phase;
        end
    end

    // The kernel word is looked up alongside the history read, so both
    // arrive in the same cycle.
    always_ff @(posedge clk)
    begin
        coef_reg <= ppi_pkg::tap_coef(issue.tap);
        prod_reg <= coef_reg * $signed(ram_rdata);
        if (s2_tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rounded = acc_reg + ppi_pkg::ROUND_HALF;
    assign shifted = rounded >>> ppi_pkg::ROUND_SHIFT;

    always_comb
    begin
        result.push  = done_reg;
        result.phase = done_phase_reg;
        if (shifted > ppi_pkg::SAT_MAX)
        begin
            result.value = ppi_pkg::SAMPLE_W'(ppi_pkg::SAT_MAX);
        end
        else if (shifted < ppi_pkg::SAT_MIN)
        begin
            result.value = ppi_pkg::SAMPLE_W'(ppi_pkg::SAT_MIN);
        end
        else
        begin
            result.value = shifted[ppi_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ----- hdl/ppi_fifo.sv -----
// -----------------------------------------------------------------------------
// Polyphase interpolator result queue
// Holds the output phases of one sample until downstream takes them.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppi_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppi_pkg::ppi_result_t                 result,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [ppi_pkg::SAMPLE_W-1:0]  upsampled_sample,
    output logic [ppi_pkg::PHASE_OUT_W-1:0]      phase_index,
    output logic                                 last,
    output logic [ppi_pkg::FIFO_CNT_W-1:0]       count
);

    localparam int PW = ppi_pkg::FIFO_PTR_W;
    localparam int CW = ppi_pkg::FIFO_CNT_W;

    logic signed [ppi_pkg::SAMPLE_W-1:0] value_reg [ppi_pkg::FIFO_DEPTH];
    logic [ppi_pkg::PHASE_W-1:0]         phase_reg [ppi_pkg::FIFO_DEPTH];
    logic [PW-1:0]                       wr_ptr_reg;
    logic [PW-1:0]                       rd_ptr_reg;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic                                pop;
    logic [ppi_pkg::PHASE_W-1:0]         head_phase;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign count        = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (result.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!result.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (result.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(ppi_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(ppi_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.push)
        begin
            value_reg[wr_ptr_reg] <= result.value;
            phase_reg[wr_ptr_reg] <= result.phase;
        end
    end

    assign head_phase       = phase_reg[rd_ptr_reg];
    assign upsampled_sample = value_reg[rd_ptr_reg];
    assign phase_index      = ppi_pkg::phase_out(head_phase);
    assign last             = (head_phase == ppi_pkg::PHASE_W'(ppi_pkg::FACTOR - 1));

endmodule

// ----- hdl/polyphase_interpolator_unit.sv -----
// Each output phase takes one history memory read and one product per kernel tap, issued
// from the single multiply-accumulate; a new sample is taken only once all 257 kernel
// taps of the previous one have been issued, at one history memory read per cycle while
// the result queue has room reserved for each phase; output stalls may hold the walk.
// Reset: asynchronous; afterwards a pass zeroes all 520 history memory words, during
// which no sample is taken.
// -----------------------------------------------------------------------------
// Polyphase interpolator unit
// Eight-channel four-times FIR interpolator with memory-held sample histories.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyphase_interpolator_unit_assert.svh"

module polyphase_interpolator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [ppi_pkg::CHAN_IN_W-1:0]        channel,
    input  logic signed [ppi_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [ppi_pkg::SAMPLE_W-1:0]  upsampled_sample,
    output logic [ppi_pkg::PHASE_OUT_W-1:0]      phase_index,
    output logic                                 last
);

    ppi_pkg::ppi_wr_t                      ram_wr;
    logic [ppi_pkg::MEM_ADDR_W-1:0]        ram_rd_addr;
    logic [ppi_pkg::SAMPLE_W-1:0]          ram_rdata;
    ppi_pkg::ppi_issue_t                   issue;
    ppi_pkg::ppi_result_t                  result;
    logic [ppi_pkg::FIFO_CNT_W-1:0]        credit_used;
    logic [ppi_pkg::FIFO_CNT_W-1:0]        fifo_count;
    logic                                  result_pop;
    logic                                  queue_room;

    assign result_pop = result_valid && result_ready;
    assign queue_room = (fifo_count < ppi_pkg::FIFO_CNT_W'(ppi_pkg::FIFO_DEPTH));

    ppi_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .channel     (channel),
        .sample      (sample),
        .result_pop  (result_pop),
        .ram_wr      (ram_wr),
        .ram_rd_addr (ram_rd_addr),
        .issue       (issue),
        .credit_used (credit_used)
    );

    ppi_ram #(
        .WIDTH (ppi_pkg::SAMPLE_W),
        .DEPTH (ppi_pkg::MEM_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    ppi_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

    ppi_fifo u_fifo (
        .clk              (clk),
        .rst_n            (rst_n),
        .result           (result),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .upsampled_sample (upsampled_sample),
        .phase_index      (phase_index),
        .last             (last),
        .count            (fifo_count)
    );

    // Every queued result must have been reserved before its phase started.
    `PPI_ASSERT_NEVER(a_queue_within_credit, clk, rst_n, fifo_count > credit_used)
    `PPI_ASSERT_IMPL(a_push_has_room, clk, rst_n, result.push, queue_room)
    `PPI_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, item_valid && item_ready, !item_ready)

endmodule

// ----- test/polyphase_interpolator_unit_test.sv -----
// -----------------------------------------------------------------------------
// Polyphase interpolator unit testbench
// Sends samples to the eight-channel interpolator and checks every output phase
// against a predictor that rebuilds the windowed-sinc kernel and the per-channel
// sample histories, under random input gaps and output stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyphase_interpolator_unit_test;

    localparam int FACTOR      = ppi_pkg::FACTOR;
    localparam int TAPS        = ppi_pkg::TAPS_PER_INPUT;
    localparam int CHANNELS    = ppi_pkg::CHANNELS;
    localparam int CHAN_IN_W   = ppi_pkg::CHAN_IN_W;
    localparam int SAMPLE_W    = ppi_pkg::SAMPLE_W;
    localparam int PHASE_OUT_W = ppi_pkg::PHASE_OUT_W;

    localparam int HISTORY_LEN = TAPS + 1;
    localparam int KERNEL_LEN  = TAPS * FACTOR + 1;

    // Kernel construction constants, Q30 unless noted.
    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned PI_Q28      = 64'd843314857;
    localparam longint          WIN_A0      = 64'sd450971566;
    localparam longint          WIN_A2      = 64'sd85899346;
    localparam longint          TURN        = 4 * FACTOR;
    localparam longint          COEF_HI     = 64'sd131071;
    localparam longint          COEF_LO     = -64'sd131072;

    localparam int IDLE_LIMIT  = 10000;
    localparam int HOLD_CYCLES = 1500;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [PHASE_OUT_W-1:0]     phase;
        logic                       last_flag;
    } phase_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_ready;
    logic [CHAN_IN_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [SAMPLE_W-1:0]  upsampled_sample;
    logic [PHASE_OUT_W-1:0]      phase_index;
    logic                        last;

    int                          kernel_coef [KERNEL_LEN];
    logic signed [SAMPLE_W-1:0]  history [CHANNELS][HISTORY_LEN];
    int                          write_slot [CHANNELS];
    phase_result_t               expected_phases [$];

    int                          error_count;
    int                          idle_cycles;
    int                          ready_hold_cycles;
    bit                          tx_burst;
    bit                          rx_burst;

    polyphase_interpolator_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .channel          (channel),
        .sample           (sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .upsampled_sample (upsampled_sample),
        .phase_index      (phase_index),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sine of an angle in turns scaled by 2^32, Taylor series to the 13th power.
    function automatic longint sin_q30(logic [31:0] ang);
        longint unsigned frac;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        int              k;
        frac = {34'd0, ang[29:0]};
        if (ang[30])
        begin
            frac = 64'd1073741824 - frac;
        end
        x    = (frac * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (k = 1; k <= 6; k++)
        begin
            divisor = (2 * k) * (2 * k + 1);
            term    = ((term * x2) >> 30) / divisor;
            if (k % 2 == 1)
            begin
                acc = acc - $signed(term);
            end
            else
            begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        return ang[31] ? -acc : acc;
    endfunction

    function automatic longint cos_q30(logic [31:0] ang);
        logic [31:0] shifted;
        shifted = ang + 32'h4000_0000;
        return sin_q30(shifted);
    endfunction

    // Blackman-windowed sinc, normalised to a DC gain of FACTOR in Q2.16.
    function automatic void build_kernel();
        longint          raw [KERNEL_LEN];
        longint          total;
        longint          d;
        longint          dm;
        longint          s;
        longint          sc;
        longint          w;
        longint          num;
        longint          c;
        longint unsigned smag;
        longint unsigned dmag;
        longint unsigned mag;
        longint unsigned q;
        logic [63:0]     wide;
        logic [31:0]     a;
        logic [31:0]     a1;
        logic [31:0]     a2;
        int              i;
        total = 0;
        for (i = 0; i < KERNEL_LEN; i++)
        begin
            d = 2 * i - (KERNEL_LEN - 1);
            if (d == 0)
            begin
                sc = ONE_Q30;
            end
            else
            begin
                dm   = ((d % TURN) + TURN) % TURN;
                wide = (dm << 32) / TURN;
                a    = wide[31:0];
                s    = sin_q30(a);
                smag = (s < 0) ? -s : s;
                dmag = (d < 0) ? -d : d;
                q    = ((smag * (2 * FACTOR)) << 28) / (PI_Q28 * dmag);
                sc   = ((s < 0) != (d < 0)) ? -$signed(q) : $signed(q);
            end
            wide   = (longint'(i) << 32) / (KERNEL_LEN - 1);
            a1     = wide[31:0];
            wide   = (longint'(2 * i) << 32) / (KERNEL_LEN - 1);
            a2     = wide[31:0];
            w      = WIN_A0 - cos_q30(a1) / 2 + (cos_q30(a2) * WIN_A2) / ONE_Q30;
            raw[i] = (sc * w) / ONE_Q30;
            total  = total + raw[i];
        end
        for (i = 0; i < KERNEL_LEN; i++)
        begin
            c = 0;
            if (total > 0)
            begin
                num = raw[i] * FACTOR * 65536;
                mag = (num < 0) ? -num : num;
                q   = (mag + total / 2) / total;
                c   = (num < 0) ? -$signed(q) : $signed(q);
            end
            if (c > COEF_HI)
            begin
                c = COEF_HI;
            end
            if (c < COEF_LO)
            begin
                c = COEF_LO;
            end
            kernel_coef[i] = int'(c);
        end
    endfunction

    // Stores one sample and queues the FACTOR output phases it produces.
    function automatic void predict_phases(logic [CHAN_IN_W-1:0] ch,
                                           logic signed [SAMPLE_W-1:0] smp);
        int            c;
        int            slot;
        int            rd;
        int            t;
        int            ph;
        longint        acc;
        longint        r;
        phase_result_t res;
        c    = int'(ch) % CHANNELS;
        slot = write_slot[c];
        history[c][slot] = smp;
        slot = (slot + 1) % HISTORY_LEN;
        write_slot[c] = slot;
        for (ph = 0; ph < FACTOR; ph++)
        begin
            acc = 0;
            rd  = slot;
            for (t = ph; t < KERNEL_LEN; t += FACTOR)
            begin
                rd  = (rd == 0) ? HISTORY_LEN - 1 : rd - 1;
                acc = acc + longint'(kernel_coef[t]) * longint'(history[c][rd]);
            end
            r = (acc + 32768) >>> 16;
            if (r > 32767)
            begin
                r = 32767;
            end
            if (r < -32768)
            begin
                r = -32768;
            end
            res.value     = r[SAMPLE_W-1:0];
            res.phase     = PHASE_OUT_W'(ph);
            res.last_flag = (ph == FACTOR - 1);
            expected_phases.push_back(res);
        end
    endfunction

    task automatic send_sample(input logic [CHAN_IN_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        channel    <= ch;
        sample     <= smp;
        do @(posedge clk); while (!item_ready);
        predict_phases(ch, smp);
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (expected_phases.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        int n;
        send_sample(3'd0, 16'sh7FFF);
        send_sample(3'd0, 16'sh8000);
        send_sample(3'd0, 16'sh0000);
        send_sample(3'd0, 16'sh0001);
        send_sample(3'd0, 16'shFFFF);
        // A lone full-scale impulse walks the first kernel taps out phase by phase.
        send_sample(3'd3, 16'sh7FFF);
        for (n = 0; n < 4; n++)
        begin
            send_sample(3'd3, 16'sh0000);
        end
        for (n = 0; n < CHANNELS; n++)
        begin
            send_sample(CHAN_IN_W'(n), (n % 2 == 1) ? 16'shAAAA : 16'sh5555);
        end
        send_sample(3'd7, 16'sh8000);
        send_sample(3'd7, 16'sh7FFF);
    endtask

    // The history is filled with full-scale samples whose signs follow the taps of one
    // phase (or oppose them, in the second run), so that phase's sum overflows and has to saturate.
    task automatic test_overdrive();
        int                   run;
        int                   ph;
        int                   k;
        logic [CHAN_IN_W-1:0] ch;
        logic                 neg;
        for (run = 0; run < 2; run++)
        begin
            ch       = (run == 0) ? 3'd2 : 3'd6;
            ph       = (run == 0) ? 2 : 1;
            neg      = (run == 1);
            tx_burst = (run == 0);
            rx_burst = (run == 0);
            for (k = (KERNEL_LEN - 1 - ph) / FACTOR; k >= 0; k--)
            begin
                send_sample(ch, ((kernel_coef[ph + k * FACTOR] >= 0) != neg) ?
                                16'sh7FFF : 16'sh8000);
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int n;
        ready_hold_cycles = HOLD_CYCLES;
        for (n = 0; n < 16; n++)
        begin
            send_sample(CHAN_IN_W'($urandom_range(0, 7)), SAMPLE_W'($urandom));
        end
    endtask

    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 20; n++)
        begin
            if (n == 10)
            begin
                wait_for_drain();
            end
            send_sample(CHAN_IN_W'($urandom_range(0, 7)), SAMPLE_W'($urandom));
        end
    endtask

    task automatic test_random();
        int                         n;
        logic [CHAN_IN_W-1:0]       run_channel;
        logic [CHAN_IN_W-1:0]       ch;
        logic signed [SAMPLE_W-1:0] smp;
        run_channel = '0;
        for (n = 0; n < 300; n++)
        begin
            if (n % 40 == 0)
            begin
                tx_burst    = ($urandom_range(0, 3) == 0);
                rx_burst    = ($urandom_range(0, 3) == 0);
                run_channel = CHAN_IN_W'($urandom_range(0, 7));
            end
            // Half the samples go to one channel so its history wraps round.
            ch = ($urandom_range(0, 1) == 0) ? run_channel : CHAN_IN_W'($urandom_range(0, 7));
            case ($urandom_range(0, 2))
                0:       smp = SAMPLE_W'($urandom);
                1:       smp = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
                default: smp = $signed(10'($urandom));
            endcase
            send_sample(ch, smp);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Output side: a random stall before each transfer outside bursts, or one long hold when asked.
    initial
    begin : receiver
        int gap;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (ready_hold_cycles != 0)
            begin
                gap = ready_hold_cycles;
                ready_hold_cycles = 0;
            end
            else
            begin
                gap = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    always @(posedge clk)
    begin : phase_checker
        phase_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_phases.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected output value %0d phase %0d last %0b",
                             $realtime, upsampled_sample, phase_index, last);
                end
            end
            else
            begin
                want = expected_phases.pop_front();
                if (upsampled_sample !== want.value || phase_index !== want.phase ||
                    last !== want.last_flag)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: output mismatch: expected value %0d phase %0d last %0b, got value %0d phase %0d last %0b",
                                 $realtime, want.value, want.phase, want.last_flag,
                                 upsampled_sample, phase_index, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("polyphase_interpolator_unit_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int c;
        int k;
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        channel           = '0;
        sample            = '0;
        error_count       = 0;
        idle_cycles       = 0;
        ready_hold_cycles = 0;
        tx_burst          = 1'b0;
        rx_burst          = 1'b0;
        for (c = 0; c < CHANNELS; c++)
        begin
            write_slot[c] = 0;
            for (k = 0; k < HISTORY_LEN; k++)
            begin
                history[c][k] = '0;
            end
        end
        build_kernel();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overdrive();
        test_output_backpressure();
        test_drain_pause();
        test_random();
        wait_for_drain();
        repeat (300) @(posedge clk);
        if (error_count == 0)
        begin
            $display("polyphase_interpolator_unit_test: clean");
        end
        else
        begin
            $display("polyphase_interpolator_unit_test: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ppi_pkg.sv
hdl/ppi_ram.sv
hdl/ppi_seq.sv
hdl/ppi_mac.sv
hdl/ppi_fifo.sv
hdl/polyphase_interpolator_unit.sv
test/polyphase_interpolator_unit_test.sv
